// ----- hw/rtl/i2c_master_byte_engine_unit_defines.svh -----
// ----------------------------------------------------------------------------
// I2C master byte engine assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define I2CME_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define I2CME_ASSERT(lbl, prop, msg)
`define I2CME_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/i2cme_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared command codes, status codes and the types passed between stages.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ADDR_ERR = 2'd1;
  localparam logic [1:0] STATUS_DATA_ERR = 2'd2;

  localparam logic [1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_DISCARD_ACK = 2'd2;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [23:0] ACK_TIMEOUT_RST = 24'd10000;

  // One decoded tick: at most one command flag is set
  typedef struct packed {
    logic       cmd_start;
    logic       cmd_write;
    logic       cmd_read;
    logic       cmd_stop;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda;
  } tick_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [23:0] ack_timeout;
    logic        discard_ack;
  } cfg_t;

endpackage

// ----- hw/rtl/i2cme_front.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine front end
// Decodes the command of each tick and forms the byte to shift out.
// ----------------------------------------------------------------------------
module i2cme_front (
  input  logic             cmd_valid_i,
  input  logic [1:0]       kind_i,
  input  logic [6:0]       slave_address_i,
  input  logic             is_read_i,
  input  logic [7:0]       byte_in_i,
  input  logic             send_ack_i,
  input  logic             sda_in_i,
  output i2cme_pkg::tick_t tick_o
);
  import i2cme_pkg::*;

  kind_e kind;

  assign kind = kind_e'(kind_i);

  always_comb begin
    tick_o          = '0;
    tick_o.send_ack = send_ack_i;
    tick_o.sda      = sda_in_i;
    tick_o.tx_byte  = byte_in_i;
    if (cmd_valid_i) begin
      unique case (kind)
        KIND_START: begin
          tick_o.cmd_start = 1'b1;
          tick_o.tx_byte   = {slave_address_i, is_read_i};
        end
        KIND_WRITE: tick_o.cmd_write = 1'b1;
        KIND_READ:  tick_o.cmd_read  = 1'b1;
        KIND_STOP:  tick_o.cmd_stop  = 1'b1;
        default:    tick_o.cmd_stop  = 1'b1;
      endcase
    end
  end

endmodule

// ----- hw/rtl/i2cme_queue.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine tick queue
// Two-entry FIFO between the decoder and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cme_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  i2cme_pkg::tick_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output i2cme_pkg::tick_t pop_data_o
);
  import i2cme_pkg::*;

  tick_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/i2cme_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine sequencer
// Steps the bus state machine by one tick per popped item and registers
// the line drives and status for the output channel.
// ----------------------------------------------------------------------------
module i2cme_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  i2cme_pkg::cfg_t  cfg_i,
  input  logic             tick_valid_i,
  output logic             tick_pop_o,
  input  i2cme_pkg::tick_t tick_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             scl_out_o,
  output logic             sda_out_o,
  output logic             ready_res_o,
  output logic             done_res_o,
  output logic [1:0]       status_o,
  output logic [7:0]       read_data_o
);
  import i2cme_pkg::*;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_WLOW  = 4'd2;
  localparam logic [3:0] PH_WHIGH = 4'd3;
  localparam logic [3:0] PH_APRE  = 4'd4;
  localparam logic [3:0] PH_AREL  = 4'd5;
  localparam logic [3:0] PH_APOLL = 4'd6;
  localparam logic [3:0] PH_APOST = 4'd7;
  localparam logic [3:0] PH_RPRE  = 4'd8;
  localparam logic [3:0] PH_RHIGH = 4'd9;
  localparam logic [3:0] PH_RLOW  = 4'd10;
  localparam logic [3:0] PH_RACK  = 4'd11;
  localparam logic [3:0] PH_STOP  = 4'd12;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] delay_q, delay_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [23:0] wait_q, wait_d;
  logic        header_q, header_d;
  logic        ack_q, ack_d;
  logic [1:0]  status_q, status_d;
  logic [7:0]  rx_q, rx_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        done;

  logic        out_valid_q;
  logic        out_scl_q, out_sda_q, out_ready_q, out_done_q;
  logic [1:0]  out_status_q;
  logic [7:0]  out_rx_q;

  logic [15:0] half;
  logic [16:0] delay_inc;
  logic        tup;
  logic [23:0] wait_inc;
  logic [3:0]  bit_inc;
  logic [7:0]  shift_sh;

  assign tick_pop_o = tick_valid_i && (!out_valid_q || out_ready_i);

  // A zero half period behaves as one tick
  assign half      = (cfg_i.half_period == 16'd0) ? 16'd1 : cfg_i.half_period;
  assign delay_inc = {1'b0, delay_q} + 17'd1;
  assign tup       = (delay_inc >= {1'b0, half});
  assign wait_inc  = wait_q + 24'd1;
  assign bit_inc   = bit_q + 4'd1;
  assign shift_sh  = {shift_q[6:0], 1'b0};

  always_comb begin
    phase_d  = phase_q;
    delay_d  = tup ? 16'd0 : delay_inc[15:0];
    bit_d    = bit_q;
    shift_d  = shift_q;
    wait_d   = wait_q;
    header_d = header_q;
    ack_d    = ack_q;
    status_d = status_q;
    rx_d     = rx_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    done     = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        delay_d = delay_q;
        if (tick_i.cmd_start || tick_i.cmd_write || tick_i.cmd_read || tick_i.cmd_stop) begin
          bit_d   = 4'd0;
          delay_d = 16'd0;
        end
        if (tick_i.cmd_start) begin
          header_d = 1'b1;
          shift_d  = tick_i.tx_byte;
          sda_d    = 1'b1;
          scl_d    = 1'b1;
          phase_d  = PH_START;
        end else if (tick_i.cmd_write) begin
          header_d = 1'b0;
          shift_d  = tick_i.tx_byte;
          sda_d    = tick_i.tx_byte[7];
          phase_d  = PH_WLOW;
        end else if (tick_i.cmd_read) begin
          ack_d   = tick_i.send_ack;
          shift_d = 8'd0;
          sda_d   = 1'b1;
          phase_d = PH_RPRE;
        end else if (tick_i.cmd_stop) begin
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = PH_STOP;
        end
      end
      PH_START: begin
        if (tup) begin
          if (bit_q == 4'd0) begin
            sda_d = 1'b0;
            bit_d = 4'd1;
          end else if (bit_q == 4'd1) begin
            scl_d = 1'b0;
            bit_d = 4'd2;
          end else begin
            bit_d   = 4'd0;
            sda_d   = shift_q[7];
            phase_d = PH_WLOW;
          end
        end
      end
      PH_WLOW: begin
        if (tup) begin
          scl_d   = 1'b1;
          phase_d = PH_WHIGH;
        end
      end
      PH_WHIGH: begin
        if (tup) begin
          scl_d   = 1'b0;
          shift_d = shift_sh;
          if (bit_inc < 4'd8) begin
            bit_d   = bit_inc;
            sda_d   = shift_sh[7];
            phase_d = PH_WLOW;
          end else begin
            bit_d   = 4'd0;
            phase_d = PH_APRE;
          end
        end
      end
      PH_APRE: begin
        if (tup) begin
          sda_d   = 1'b1;
          phase_d = PH_AREL;
        end
      end
      PH_AREL: begin
        if (tup) begin
          scl_d   = 1'b1;
          wait_d  = 24'd0;
          phase_d = PH_APOLL;
        end
      end
      PH_APOLL: begin
        // Poll every tick, no phase timer here
        delay_d = delay_q;
        if (!tick_i.sda) begin
          ack_d   = 1'b0;
          delay_d = 16'd0;
          phase_d = PH_APOST;
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= cfg_i.ack_timeout) begin
            ack_d   = 1'b1;
            delay_d = 16'd0;
            phase_d = PH_APOST;
          end
        end
      end
      PH_APOST: begin
        if (tup) begin
          scl_d = 1'b0;
          if (ack_q && !cfg_i.discard_ack) begin
            status_d = header_q ? STATUS_ADDR_ERR : STATUS_DATA_ERR;
          end else begin
            status_d = STATUS_OK;
          end
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_RPRE: begin
        if (tup) begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], tick_i.sda};
          phase_d = PH_RHIGH;
        end
      end
      PH_RHIGH: begin
        if (tup) begin
          scl_d   = 1'b0;
          phase_d = PH_RLOW;
        end
      end
      PH_RLOW: begin
        if (tup) begin
          scl_d = 1'b1;
          if (bit_inc < 4'd8) begin
            bit_d   = bit_inc;
            shift_d = {shift_q[6:0], tick_i.sda};
            phase_d = PH_RHIGH;
          end else begin
            bit_d   = 4'd0;
            sda_d   = ~ack_q;
            phase_d = PH_RACK;
          end
        end
      end
      PH_RACK: begin
        if (tup) begin
          scl_d    = 1'b0;
          sda_d    = 1'b1;
          rx_d     = shift_q;
          status_d = STATUS_OK;
          done     = 1'b1;
          phase_d  = PH_IDLE;
        end
      end
      PH_STOP: begin
        if (tup) begin
          if (bit_q == 4'd0) begin
            scl_d = 1'b1;
            bit_d = 4'd1;
          end else if (bit_q == 4'd1) begin
            sda_d = 1'b1;
            bit_d = 4'd2;
          end else begin
            bit_d    = 4'd0;
            status_d = STATUS_OK;
            done     = 1'b1;
            phase_d  = PH_IDLE;
          end
        end
      end
      default: begin
        // Drop an unused code back to idle without a done pulse
        delay_d = 16'd0;
        bit_d   = 4'd0;
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      delay_q  <= 16'd0;
      bit_q    <= 4'd0;
      shift_q  <= 8'd0;
      wait_q   <= 24'd0;
      header_q <= 1'b0;
      ack_q    <= 1'b0;
      status_q <= STATUS_OK;
      rx_q     <= 8'd0;
      scl_q    <= 1'b1;
      sda_q    <= 1'b1;
    end else if (tick_pop_o) begin
      phase_q  <= phase_d;
      delay_q  <= delay_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      wait_q   <= wait_d;
      header_q <= header_d;
      ack_q    <= ack_d;
      status_q <= status_d;
      rx_q     <= rx_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_pop_o) begin
      out_scl_q    <= scl_d;
      out_sda_q    <= sda_d;
      out_ready_q  <= (phase_q == PH_IDLE);
      out_done_q   <= done;
      out_status_q <= status_d;
      out_rx_q     <= rx_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = out_scl_q;
  assign sda_out_o   = out_sda_q;
  assign ready_res_o = out_ready_q;
  assign done_res_o  = out_done_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_rx_q;

endmodule

// ----- hw/rtl/i2c_master_byte_engine_unit.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-driven I2C master: start plus address, write, read and stop commands.
// ----------------------------------------------------------------------------
// Each input transaction is one timing tick and yields exactly one output
// transaction carrying the SCL/SDA drives, idle flag, done pulse, status and
// last read byte. One tick is taken per clock cycle while the tick queue has
// room and the output channel is not stalled; each tick passes through the
// two-entry tick queue and the single-tick sequencer step into the output register.
// Configuration writes are taken at any time and should be issued while idle.
`include "i2c_master_byte_engine_unit_defines.svh"

module i2c_master_byte_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_valid_i,
  input  logic [1:0]  kind_i,
  input  logic [6:0]  slave_address_i,
  input  logic        is_read_i,
  input  logic [7:0]  byte_in_i,
  input  logic        send_ack_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        ready_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [7:0]  read_data_o
);
  import i2cme_pkg::*;

  cfg_t  cfg_q;
  tick_t front_tick;
  tick_t q_tick;
  logic  q_valid;
  logic  q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HALF_PERIOD_RST;
      cfg_q.ack_timeout <= ACK_TIMEOUT_RST;
      cfg_q.discard_ack <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HALF_PERIOD: cfg_q.half_period <= cfg_data_i[15:0];
        CFG_ACK_TIMEOUT: cfg_q.ack_timeout <= cfg_data_i;
        CFG_DISCARD_ACK: cfg_q.discard_ack <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  i2cme_front u_front (
    .cmd_valid_i     (cmd_valid_i),
    .kind_i          (kind_i),
    .slave_address_i (slave_address_i),
    .is_read_i       (is_read_i),
    .byte_in_i       (byte_in_i),
    .send_ack_i      (send_ack_i),
    .sda_in_i        (sda_in_i),
    .tick_o          (front_tick)
  );

  i2cme_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_tick),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_pop),
    .pop_data_o   (q_tick)
  );

  i2cme_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .tick_valid_i (q_valid),
    .tick_pop_o   (q_pop),
    .tick_i       (q_tick),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .scl_out_o    (scl_out_o),
    .sda_out_o    (sda_out_o),
    .ready_res_o  (ready_res_o),
    .done_res_o   (done_res_o),
    .status_o     (status_o),
    .read_data_o  (read_data_o)
  );

  `I2CME_ASSERT_IMPL(a_pop_has_tick, q_pop, q_valid, "tick popped from empty queue")
  `I2CME_ASSERT_IMPL(a_pop_slot_free, q_pop, !out_valid_o || out_ready_i, "result overwritten")
  `I2CME_ASSERT_IMPL(a_done_not_idle, out_valid_o && done_res_o, !ready_res_o,
                     "done reported on an idle tick")
  `I2CME_ASSERT(a_status_code, !out_valid_o || status_o != 2'd3, "undefined status code")

endmodule

// ----- tb/sv/tb_i2c_master_byte_engine_unit.sv -----
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Sends timing ticks with random gaps and random result stalls, keeps a
// behavioral copy of the engine and checks every result tick field by field.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cme_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_LIMIT  = 1000;
  localparam int unsigned ROUND_TICKS  = 40;
  localparam int unsigned RESET_HOLD   = 104;
  localparam int unsigned LONG_HOLD    = 24;
  localparam int          NO_ACK       = -1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_WR_LOW, ST_WR_HIGH, ST_ACK_SETUP, ST_ACK_RELEASE,
    ST_ACK_POLL, ST_ACK_HOLD, ST_RD_SETUP, ST_RD_HIGH, ST_RD_LOW, ST_RD_ACK,
    ST_STOP
  } bus_state_e;

  typedef struct {
    logic       cmd_valid;
    kind_e      kind;
    logic [6:0] addr;
    logic       rw;
    logic [7:0] data;
    logic       send_ack;
    logic       sda;
  } bus_tick_t;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       idle;
    logic       done;
    logic [1:0] status;
    logic [7:0] rdata;
  } line_state_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        cmd_valid_i;
  logic [1:0]  kind_i;
  logic [6:0]  slave_address_i;
  logic        is_read_i;
  logic [7:0]  byte_in_i;
  logic        send_ack_i;
  logic        sda_in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        scl_out_o;
  logic        sda_out_o;
  logic        ready_res_o;
  logic        done_res_o;
  logic [1:0]  status_o;
  logic [7:0]  read_data_o;

  i2c_master_byte_engine_unit u_dut (.*);

  // Engine copy: configuration and state
  logic [15:0] cfg_half;
  logic [23:0] cfg_timeout;
  logic        cfg_discard;
  bus_state_e  st;
  logic [15:0] dly;
  logic [3:0]  bits;
  logic [7:0]  shreg;
  logic [23:0] polls;
  logic        hdr;
  logic        ack_flag;
  logic [1:0]  stat;
  logic [7:0]  rx_byte;
  logic        scl_lvl;
  logic        sda_lvl;

  line_state_t line_state_q[$];

  // Slave behavior for the current command
  int          ack_after;
  logic [7:0]  slave_byte;
  bit          paced;

  int unsigned n_fail;
  int unsigned n_ticks;
  int unsigned n_results;
  int unsigned n_cmds;
  int unsigned n_done;
  int unsigned n_addr_err;
  int unsigned n_data_err;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void engine_reset();
    cfg_half    = HALF_PERIOD_RST;
    cfg_timeout = ACK_TIMEOUT_RST;
    cfg_discard = 1'b0;
    st          = ST_IDLE;
    dly         = '0;
    bits        = '0;
    shreg       = '0;
    polls       = '0;
    hdr         = 1'b0;
    ack_flag    = 1'b0;
    stat        = STATUS_OK;
    rx_byte     = '0;
    scl_lvl     = 1'b1;
    sda_lvl     = 1'b1;
  endfunction

  // A zero half period behaves as one tick
  function automatic bit phase_elapsed();
    int unsigned h;
    int unsigned d;
    h = (cfg_half == 0) ? 1 : cfg_half;
    d = dly;
    if (d + 1 >= h) begin
      dly = '0;
      return 1'b1;
    end
    dly = dly + 16'd1;
    return 1'b0;
  endfunction

  function automatic void enter(bus_state_e s);
    st  = s;
    dly = '0;
  endfunction

  function automatic line_state_t predict_bus_tick(bus_tick_t t);
    line_state_t r;
    logic        was_idle;
    logic        dn;
    was_idle = (st == ST_IDLE);
    dn       = 1'b0;
    case (st)
      ST_IDLE: begin
        if (t.cmd_valid) begin
          n_cmds++;
          bits = '0;
          case (t.kind)
            KIND_START: begin
              hdr     = 1'b1;
              shreg   = {t.addr, t.rw};
              sda_lvl = 1'b1;
              scl_lvl = 1'b1;
              enter(ST_START);
            end
            KIND_WRITE: begin
              hdr     = 1'b0;
              shreg   = t.data;
              sda_lvl = shreg[7];
              enter(ST_WR_LOW);
            end
            KIND_READ: begin
              ack_flag = t.send_ack;
              shreg    = '0;
              sda_lvl  = 1'b1;
              enter(ST_RD_SETUP);
            end
            default: begin
              scl_lvl = 1'b0;
              sda_lvl = 1'b0;
              enter(ST_STOP);
            end
          endcase
        end
      end
      ST_START: begin
        if (phase_elapsed()) begin
          if (bits == 0) begin
            sda_lvl = 1'b0;
            bits    = 4'd1;
          end else if (bits == 1) begin
            scl_lvl = 1'b0;
            bits    = 4'd2;
          end else begin
            bits    = '0;
            sda_lvl = shreg[7];
            enter(ST_WR_LOW);
          end
        end
      end
      ST_WR_LOW: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b1;
          enter(ST_WR_HIGH);
        end
      end
      ST_WR_HIGH: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b0;
          bits    = bits + 4'd1;
          shreg   = shreg << 1;
          if (bits < 8) begin
            sda_lvl = shreg[7];
            enter(ST_WR_LOW);
          end else begin
            bits = '0;
            enter(ST_ACK_SETUP);
          end
        end
      end
      ST_ACK_SETUP: begin
        if (phase_elapsed()) begin
          sda_lvl = 1'b1;
          enter(ST_ACK_RELEASE);
        end
      end
      ST_ACK_RELEASE: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b1;
          polls   = '0;
          enter(ST_ACK_POLL);
        end
      end
      ST_ACK_POLL: begin
        if (!t.sda) begin
          ack_flag = 1'b0;
          enter(ST_ACK_HOLD);
        end else begin
          polls = polls + 24'd1;
          if (polls >= cfg_timeout) begin
            ack_flag = 1'b1;
            enter(ST_ACK_HOLD);
          end
        end
      end
      ST_ACK_HOLD: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b0;
          if (ack_flag && !cfg_discard) stat = hdr ? STATUS_ADDR_ERR : STATUS_DATA_ERR;
          else stat = STATUS_OK;
          dn = 1'b1;
          enter(ST_IDLE);
        end
      end
      ST_RD_SETUP: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b1;
          shreg   = {shreg[6:0], t.sda};
          enter(ST_RD_HIGH);
        end
      end
      ST_RD_HIGH: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b0;
          enter(ST_RD_LOW);
        end
      end
      ST_RD_LOW: begin
        if (phase_elapsed()) begin
          bits = bits + 4'd1;
          if (bits < 8) begin
            scl_lvl = 1'b1;
            shreg   = {shreg[6:0], t.sda};
            enter(ST_RD_HIGH);
          end else begin
            bits    = '0;
            sda_lvl = !ack_flag;
            scl_lvl = 1'b1;
            enter(ST_RD_ACK);
          end
        end
      end
      ST_RD_ACK: begin
        if (phase_elapsed()) begin
          scl_lvl = 1'b0;
          sda_lvl = 1'b1;
          rx_byte = shreg;
          stat    = STATUS_OK;
          dn      = 1'b1;
          enter(ST_IDLE);
        end
      end
      ST_STOP: begin
        if (phase_elapsed()) begin
          if (bits == 0) begin
            scl_lvl = 1'b1;
            bits    = 4'd1;
          end else if (bits == 1) begin
            sda_lvl = 1'b1;
            bits    = 4'd2;
          end else begin
            bits = '0;
            stat = STATUS_OK;
            dn   = 1'b1;
            enter(ST_IDLE);
          end
        end
      end
      default: begin
        bits = '0;
        enter(ST_IDLE);
      end
    endcase
    if (dn) begin
      n_done++;
      if (stat == STATUS_ADDR_ERR) n_addr_err++;
      if (stat == STATUS_DATA_ERR) n_data_err++;
    end
    r.scl    = scl_lvl;
    r.sda    = sda_lvl;
    r.idle   = was_idle;
    r.done   = dn;
    r.status = stat;
    r.rdata  = rx_byte;
    return r;
  endfunction

  // SDA as the addressed slave drives it in the current engine state
  function automatic logic slave_sda();
    int idx;
    case (st)
      ST_ACK_POLL: begin
        if (ack_after < 0) return 1'b1;
        return (int'(polls) >= ack_after) ? 1'b0 : 1'b1;
      end
      ST_RD_SETUP: return slave_byte[7];
      ST_RD_LOW: begin
        idx = bits + 1;
        if (idx < 8) return slave_byte[7 - idx];
        return logic'($urandom_range(0, 1));
      end
      default: return logic'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic bus_tick_t random_tick();
    bus_tick_t t;
    t.cmd_valid = ($urandom_range(0, 3) == 0);
    t.kind      = kind_e'($urandom_range(0, 3));
    t.addr      = 7'($urandom_range(0, 127));
    t.rw        = logic'($urandom_range(0, 1));
    t.data      = 8'($urandom_range(0, 255));
    t.send_ack  = logic'($urandom_range(0, 1));
    t.sda       = slave_sda();
    return t;
  endfunction

  function automatic bus_tick_t quiet_tick();
    bus_tick_t t;
    t           = random_tick();
    t.cmd_valid = 1'b0;
    return t;
  endfunction

  function automatic bus_tick_t make_command(kind_e k, logic [6:0] a, logic rw,
                                             logic [7:0] b, logic ack);
    bus_tick_t t;
    t           = random_tick();
    t.cmd_valid = 1'b1;
    t.kind      = k;
    t.addr      = a;
    t.rw        = rw;
    t.data      = b;
    t.send_ack  = ack;
    return t;
  endfunction

  // Mostly an ACK inside the window, sometimes none or a late one
  function automatic int pick_ack();
    int v;
    v = $urandom_range(0, 9);
    if (cfg_timeout == 0) return 0;
    if (v < 7) return $urandom_range(0, cfg_timeout - 1);
    if (v < 8) return NO_ACK;
    return $urandom_range(0, cfg_timeout + 2);
  endfunction

  function automatic void flag_mismatch(string field, int exp_v, int act_v);
    n_fail++;
    $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
  endfunction

  task automatic send_tick(input bus_tick_t t);
    int          gap;
    line_state_t r;
    gap = paced ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_valid_i     <= t.cmd_valid;
    kind_i          <= t.kind;
    slave_address_i <= t.addr;
    is_read_i       <= t.rw;
    byte_in_i       <= t.data;
    send_ack_i      <= t.send_ack;
    sda_in_i        <= t.sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = predict_bus_tick(t);
    line_state_q.push_back(r);
    n_ticks++;
  endtask

  // Issue one command and feed ticks until the engine is idle again
  task automatic run_command(input bus_tick_t cmd, input int ack_i, input logic [7:0] rd_i);
    ack_after  = ack_i;
    slave_byte = rd_i;
    send_tick(cmd);
    while (st != ST_IDLE) send_tick(random_tick());
  endtask

  // Hold the sender until every expected result has come
  task automatic settle();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (line_state_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (line_state_q.size() != 0) begin
      n_fail++;
      $error("%0d result(s) never arrived", line_state_q.size());
      line_state_q.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_HALF_PERIOD: cfg_half    = val[15:0];
      CFG_ACK_TIMEOUT: cfg_timeout = val;
      CFG_DISCARD_ACK: cfg_discard = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] half, input logic [23:0] tmo, input logic disc);
    settle();
    cfg_write(CFG_HALF_PERIOD, {8'd0, half});
    cfg_write(CFG_ACK_TIMEOUT, tmo);
    cfg_write(CFG_DISCARD_ACK, {23'd0, disc});
    cfg_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  task automatic random_frame();
    logic rw;
    int   n;
    rw = logic'($urandom_range(0, 1));
    n  = $urandom_range(1, 3);
    run_command(make_command(KIND_START, 7'($urandom_range(0, 127)), rw, 8'h00, 1'b0),
                pick_ack(), 8'h00);
    for (int i = 0; i < n; i++) begin
      if (rw)
        run_command(make_command(KIND_READ, 7'h00, 1'b0, 8'h00, logic'(i != n - 1)),
                    0, 8'($urandom_range(0, 255)));
      else
        run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'($urandom_range(0, 255)),
                                 1'b0), pick_ack(), 8'h00);
    end
    // Leave some frames without a stop
    if ($urandom_range(0, 7) != 0)
      run_command(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
  endtask

  task automatic test_idle_after_reset();
    repeat (8) send_tick(quiet_tick());
  endtask

  // Run the first stop phase through the reset half period, then shorten it
  task automatic test_reset_timing();
    ack_after  = 0;
    slave_byte = '0;
    send_tick(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0));
    repeat (RESET_HOLD) send_tick(quiet_tick());
    configure(16'd1, 24'd4, 1'b0);
    while (st != ST_IDLE) send_tick(random_tick());
    settle();
  endtask

  task automatic test_byte_frames();
    configure(16'd1, 24'd4, 1'b0);
    run_command(make_command(KIND_START, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0), 3, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0), 1, 8'h00);
    run_command(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
    run_command(make_command(KIND_START, 7'h7F, 1'b1, 8'h00, 1'b0), 0, 8'h00);
    run_command(make_command(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b1), 0, 8'hFF);
    run_command(make_command(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b1), 0, 8'h5A);
    run_command(make_command(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
    run_command(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
    configure(16'd2, 24'd4, 1'b0);
    run_command(make_command(KIND_START, 7'h2A, 1'b0, 8'h00, 1'b0), 2, 8'h00);
    run_command(make_command(KIND_READ, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'hC3);
    run_command(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
  endtask

  task automatic test_ack_timeouts();
    configure(16'd1, 24'd3, 1'b0);
    run_command(make_command(KIND_START, 7'h55, 1'b0, 8'h00, 1'b0), NO_ACK, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h3C, 1'b0), NO_ACK, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h81, 1'b0), 2, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h7E, 1'b0), 3, 8'h00);
    configure(16'd1, 24'd3, 1'b1);
    run_command(make_command(KIND_START, 7'h2B, 1'b1, 8'h00, 1'b0), NO_ACK, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h01, 1'b0), NO_ACK, 8'h00);
    run_command(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0), 0, 8'h00);
  endtask

  task automatic test_config_extremes();
    // Zero half period acts as one tick; zero timeout fails on the first high sample
    configure(16'd0, 24'd0, 1'b0);
    run_command(make_command(KIND_START, 7'h11, 1'b0, 8'h00, 1'b0), NO_ACK, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h96, 1'b0), NO_ACK, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'h69, 1'b0), 0, 8'h00);
    configure(16'd1, 24'hFFFFFF, 1'b0);
    run_command(make_command(KIND_START, 7'h40, 1'b0, 8'h00, 1'b0), 12, 8'h00);
    run_command(make_command(KIND_WRITE, 7'h00, 1'b0, 8'hE7, 1'b0), 0, 8'h00);
    // Longest half period: hold the stop phase a while, then shorten it to finish
    configure(16'hFFFF, 24'd1, 1'b1);
    ack_after  = 0;
    slave_byte = '0;
    send_tick(make_command(KIND_STOP, 7'h00, 1'b0, 8'h00, 1'b0));
    repeat (LONG_HOLD) send_tick(quiet_tick());
    configure(16'd1, 24'd1, 1'b1);
    while (st != ST_IDLE) send_tick(random_tick());
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned first;
    int          pick;
    for (int round = 0; round < 3; round++) begin
      configure(16'($urandom_range(1, round + 1)), 24'($urandom_range(1, 6)),
                (round == 1) ? 1'b1 : logic'($urandom_range(0, 1)));
      paced = (round != 2);
      first = n_ticks;
      while (n_ticks - first < ROUND_TICKS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          random_frame();
        end else if (pick < 9) begin
          run_command(make_command(kind_e'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                                   logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                   logic'($urandom_range(0, 1))),
                      pick_ack(), 8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 4)) send_tick(quiet_tick());
        end
        if (round == 0 && n_ticks - first > ROUND_TICKS / 2 &&
            n_ticks - first < ROUND_TICKS / 2 + 30)
          settle();
      end
      paced = 1'b1;
    end
  endtask

  initial begin : result_monitor
    int          stall;
    line_state_t exp_r;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = paced ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      n_results++;
      if (line_state_q.size() == 0) begin
        n_fail++;
        $error("result transaction with no expectation pending");
      end else begin
        exp_r = line_state_q.pop_front();
        if (scl_out_o !== exp_r.scl) flag_mismatch("scl_out", exp_r.scl, scl_out_o);
        if (sda_out_o !== exp_r.sda) flag_mismatch("sda_out", exp_r.sda, sda_out_o);
        if (ready_res_o !== exp_r.idle) flag_mismatch("ready_res", exp_r.idle, ready_res_o);
        if (done_res_o !== exp_r.done) flag_mismatch("done_res", exp_r.done, done_res_o);
        if (status_o !== exp_r.status) flag_mismatch("status", exp_r.status, status_o);
        if (read_data_o !== exp_r.rdata) flag_mismatch("read_data", exp_r.rdata, read_data_o);
      end
    end
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= CFG_HALF_PERIOD;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    cmd_valid_i     <= 1'b0;
    kind_i          <= KIND_START;
    slave_address_i <= '0;
    is_read_i       <= 1'b0;
    byte_in_i       <= '0;
    send_ack_i      <= 1'b0;
    sda_in_i        <= 1'b1;
    cycle_count     = 0;
    n_fail          = 0;
    n_ticks         = 0;
    n_results       = 0;
    n_cmds          = 0;
    n_done          = 0;
    n_addr_err      = 0;
    n_data_err      = 0;
    ack_after       = 0;
    slave_byte      = '0;
    paced           = 1'b1;
    engine_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_after_reset();
    test_reset_timing();
    test_byte_frames();
    test_ack_timeouts();
    test_config_extremes();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d result ticks for %0d ticks sent, %0d commands accepted.",
             n_results, n_ticks, n_cmds);
    $display("%0d commands finished, %0d address and %0d data ACK timeouts reported.",
             n_done, n_addr_err, n_data_err);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/i2cme_pkg.sv
hw/rtl/i2cme_front.sv
hw/rtl/i2cme_queue.sv
hw/rtl/i2cme_engine.sv
hw/rtl/i2c_master_byte_engine_unit.sv
tb/sv/tb_i2c_master_byte_engine_unit.sv
